// ===== rtl/udpfix_pkg.sv =====
// ----------------------------------------------------------------------------
// udpfix_pkg
// Types, constants and ones' complement helpers for the IPv4/UDP fixup block.
// ----------------------------------------------------------------------------
`default_nettype none

package udpfix_pkg;

    localparam logic [15:0] WordMax      = 16'hffff;
    localparam logic [7:0]  ProtoUdp     = 8'd17;
    localparam logic [15:0] IdxLenWord   = 16'd1;
    localparam logic [15:0] IdxProtoWord = 16'd4;
    localparam logic [15:0] IdxCsumWord  = 16'd5;
    localparam logic [15:0] IdxSrcFirst  = 16'd6;
    localparam logic [15:0] IdxDstLast   = 16'd9;
    localparam logic [15:0] UdpLenOffset = 16'd2;
    localparam logic [15:0] UdpCsOffset  = 16'd3;

    // Everything the final stage needs from a packet once its last word is in.
    typedef struct packed {
        logic [16:0] header_sum;
        logic [16:0] datagram_sum;
        logic        udp;
        logic [15:0] index;
        logic [4:0]  header_words;
        logic        overflow;
        logic        odd;
    } pkt_summary_t;

    // End-around-carry add of one word to a running folded sum.
    function automatic logic [16:0] oc_add(input logic [16:0] acc, input logic [15:0] w);
        logic [17:0] s;
        begin
            s = {1'b0, acc} + {2'b00, w};
            oc_add = {1'b0, s[15:0]} + {15'd0, s[17:16]};
        end
    endfunction

    // Two folds of an 18-bit sum down to 16 bits.
    function automatic logic [15:0] oc_fold(input logic [17:0] s);
        logic [16:0] t1;
        logic [16:0] t2;
        begin
            t1 = {1'b0, s[15:0]} + {15'd0, s[17:16]};
            t2 = {1'b0, t1[15:0]} + {16'd0, t1[16]};
            oc_fold = t2[15:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ipv4_udp_length_checksum_fixup.sv =====
// ----------------------------------------------------------------------------
// ipv4_udp_length_checksum_fixup
// Streams an IPv4 packet word by word and, on its last word, produces the
// measured total length, a fresh header checksum and the UDP length and
// checksum including the pseudoheader.
//
//  Channel  Signals                                  Direction  Request
//  item     item_valid, item_ready, word,            in         one packet word
//           last, odd_tail
//  result   result_valid, result_ready,              out        one per packet
//           total_length, header_checksum,
//           udp_length, udp_checksum, is_udp,
//           length_error
//
// One word is accepted every cycle unless the input stalls; the last word of
// a packet reaches its result through the input, accumulate and finishing stages.
// Non-final words keep flowing while a result waits, and one further packet
// end can be held in the summary stage before the input stalls.
// Reset clears all valid flags and the running sums; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_udp_length_checksum_fixup
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        item_valid,
    output logic             item_ready,
    input  wire logic [15:0] word,
    input  wire logic        last,
    input  wire logic        odd_tail,

    output logic             result_valid,
    input  wire logic        result_ready,
    output logic [15:0]      total_length,
    output logic [15:0]      header_checksum,
    output logic [15:0]      udp_length,
    output logic [15:0]      udp_checksum,
    output logic             is_udp,
    output logic             length_error
);

    // Input register.
    logic        s1_valid_reg;
    logic [15:0] s1_word_reg;
    logic        s1_last_reg;
    logic        s1_odd_reg;

    // Running packet state.
    logic [15:0] word_index_reg,   word_index_next;
    logic [4:0]  header_words_reg, header_words_next;
    logic [16:0] header_sum_reg,   header_sum_next;
    logic [16:0] datagram_sum_reg, datagram_sum_next;
    logic        udp_flag_reg,     udp_flag_next;
    logic        overflow_flag_reg, overflow_flag_next;

    // Summary register and result register.
    logic                     s2_valid_reg;
    udpfix_pkg::pkt_summary_t s2_reg, s2_next;

    logic        result_valid_reg;
    logic [15:0] total_length_reg,    total_length_next;
    logic [15:0] header_checksum_reg, header_checksum_next;
    logic [15:0] udp_length_reg,      udp_length_next;
    logic [15:0] udp_checksum_reg,    udp_checksum_next;
    logic        is_udp_reg;
    logic        length_error_reg,    length_error_next;

    // Flow control.
    logic out_load_ok;
    logic s2_move;
    logic s2_free;
    logic s1_move;
    logic s2_load;
    logic in_accept;

    assign out_load_ok = !result_valid_reg || result_ready;
    assign s2_move     = s2_valid_reg && out_load_ok;
    assign s2_free     = !s2_valid_reg || s2_move;
    assign s1_move     = s1_valid_reg && (!s1_last_reg || s2_free);
    assign s2_load     = s1_move && s1_last_reg;
    assign item_ready  = !s1_valid_reg || s1_move;
    assign in_accept   = item_valid && item_ready;

    // Accumulate stage.
    logic        odd;
    logic [15:0] wm;
    logic [4:0]  hw;
    logic [15:0] hw_ext;
    logic        in_header;
    logic        in_datagram;
    logic        in_addresses;
    logic [16:0] dsum_a;

    always_comb
    begin
        odd          = s1_odd_reg && s1_last_reg;
        wm           = odd ? {s1_word_reg[15:8], 8'h00} : s1_word_reg;
        hw           = (word_index_reg == 16'd0) ? {s1_word_reg[11:8], 1'b0}
                                                 : header_words_reg;
        hw_ext       = {11'd0, hw};
        in_header    = (word_index_reg < hw_ext)
                    && (word_index_reg != udpfix_pkg::IdxLenWord)
                    && (word_index_reg != udpfix_pkg::IdxCsumWord);
        in_datagram  = (word_index_reg >= hw_ext)
                    && (word_index_reg != hw_ext + udpfix_pkg::UdpLenOffset)
                    && (word_index_reg != hw_ext + udpfix_pkg::UdpCsOffset);
        in_addresses = (word_index_reg >= udpfix_pkg::IdxSrcFirst)
                    && (word_index_reg <= udpfix_pkg::IdxDstLast);

        header_sum_next = in_header ? udpfix_pkg::oc_add(header_sum_reg, wm)
                                    : header_sum_reg;
        dsum_a          = in_datagram ? udpfix_pkg::oc_add(datagram_sum_reg, wm)
                                      : datagram_sum_reg;
        datagram_sum_next = in_addresses ? udpfix_pkg::oc_add(dsum_a, wm) : dsum_a;
        udp_flag_next   = (word_index_reg == udpfix_pkg::IdxProtoWord)
                        ? (wm[7:0] == udpfix_pkg::ProtoUdp) : udp_flag_reg;
        header_words_next = hw;

        if (word_index_reg == udpfix_pkg::WordMax)
        begin
            word_index_next    = word_index_reg;
            overflow_flag_next = 1'b1;
        end
        else
        begin
            word_index_next    = word_index_reg + 16'd1;
            overflow_flag_next = overflow_flag_reg;
        end

        s2_next.header_sum   = header_sum_next;
        s2_next.datagram_sum = datagram_sum_next;
        s2_next.udp          = udp_flag_next;
        s2_next.index        = word_index_reg;
        s2_next.header_words = hw;
        s2_next.overflow     = overflow_flag_reg;
        s2_next.odd          = odd;
    end

    // Finishing stage.
    logic [16:0] n_words;
    logic [17:0] n_bytes;
    logic        too_long;
    logic        too_short;
    logic [15:0] hdr_bytes;
    logic [15:0] ucs;

    always_comb
    begin
        n_words   = {1'b0, s2_reg.index} + 17'd1;
        n_bytes   = {n_words, 1'b0} - {17'd0, s2_reg.odd};
        too_long  = s2_reg.overflow || (n_bytes[17:16] != 2'b00);
        total_length_next = too_long ? udpfix_pkg::WordMax : n_bytes[15:0];
        hdr_bytes = {10'd0, s2_reg.header_words, 1'b0};
        too_short = !too_long && (total_length_next < hdr_bytes);
        udp_length_next   = too_short ? 16'd0 : (total_length_next - hdr_bytes);
        length_error_next = too_long || too_short;
        header_checksum_next = ~udpfix_pkg::oc_fold({1'b0, s2_reg.header_sum}
                                                    + {2'b00, total_length_next});
        ucs = ~udpfix_pkg::oc_fold({1'b0, s2_reg.datagram_sum}
                                   + {10'd0, udpfix_pkg::ProtoUdp}
                                   + {1'b0, udp_length_next, 1'b0});
        if (!s2_reg.udp)
        begin
            udp_checksum_next = 16'd0;
        end
        else if (ucs == 16'd0)
        begin
            udp_checksum_next = udpfix_pkg::WordMax;
        end
        else
        begin
            udp_checksum_next = ucs;
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            s2_valid_reg      <= 1'b0;
            result_valid_reg  <= 1'b0;
            word_index_reg    <= '0;
            header_words_reg  <= '0;
            header_sum_reg    <= '0;
            datagram_sum_reg  <= '0;
            udp_flag_reg      <= 1'b0;
            overflow_flag_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                s1_valid_reg <= item_valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s2_load;
            end
            if (out_load_ok)
            begin
                result_valid_reg <= s2_valid_reg;
            end
            if (s1_move)
            begin
                if (s1_last_reg)
                begin
                    word_index_reg    <= '0;
                    header_words_reg  <= '0;
                    header_sum_reg    <= '0;
                    datagram_sum_reg  <= '0;
                    udp_flag_reg      <= 1'b0;
                    overflow_flag_reg <= 1'b0;
                end
                else
                begin
                    word_index_reg    <= word_index_next;
                    header_words_reg  <= header_words_next;
                    header_sum_reg    <= header_sum_next;
                    datagram_sum_reg  <= datagram_sum_next;
                    udp_flag_reg      <= udp_flag_next;
                    overflow_flag_reg <= overflow_flag_next;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_word_reg <= word;
            s1_last_reg <= last;
            s1_odd_reg  <= odd_tail;
        end
        if (s2_load)
        begin
            s2_reg <= s2_next;
        end
        if (s2_move)
        begin
            total_length_reg    <= total_length_next;
            header_checksum_reg <= header_checksum_next;
            udp_length_reg      <= udp_length_next;
            udp_checksum_reg    <= udp_checksum_next;
            is_udp_reg          <= s2_reg.udp;
            length_error_reg    <= length_error_next;
        end
    end

    assign result_valid    = result_valid_reg;
    assign total_length    = total_length_reg;
    assign header_checksum = header_checksum_reg;
    assign udp_length      = udp_length_reg;
    assign udp_checksum    = udp_checksum_reg;
    assign is_udp          = is_udp_reg;
    assign length_error    = length_error_reg;

    // The packet state starts afresh after every packet end.
    assert property (@(posedge clk) disable iff (!rst_n)
        s2_load |=> (word_index_reg == 16'd0) && !overflow_flag_reg)
        else $error("packet state not cleared after last word");

    // The overflow flag only rises once the word counter has saturated.
    assert property (@(posedge clk) disable iff (!rst_n)
        overflow_flag_reg |-> (word_index_reg == udpfix_pkg::WordMax))
        else $error("overflow flag without saturated word count");

    // A UDP result never carries a zero checksum, a non-UDP one always does.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (is_udp_reg == (udp_checksum_reg != 16'd0)))
        else $error("UDP checksum inconsistent with protocol flag");

    // A result held back by the sink keeps its total length and UDP checksum.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !result_ready) |=> $stable(total_length_reg)
                                              && $stable(udp_checksum_reg))
        else $error("stalled result changed");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for ipv4_udp_length_checksum_fixup. A table of
// directed packets covers the length extremes, short and overlong packets,
// small and large header lengths, UDP and other protocols. It is followed
// by randomised packets and noise. Every accepted word request is run through
// a local model of the block. Each result request is compared field by field
// with the oldest expected result. Both channels idle and stall at random.
// ----------------------------------------------------------------------------

module tb;

    localparam logic [15:0] WordMax      = 16'hffff;
    localparam logic [15:0] PadMask      = 16'hff00;
    localparam logic [7:0]  UdpProto     = 8'd17;
    localparam logic [7:0]  TcpProto     = 8'd6;
    localparam logic [15:0] UdpTtlProto  = {8'h40, UdpProto};
    localparam logic [15:0] TcpTtlProto  = {8'h40, TcpProto};
    localparam int unsigned LenWordIdx   = 1;
    localparam int unsigned ProtoWordIdx = 4;
    localparam int unsigned CsumWordIdx  = 5;
    localparam int unsigned SrcFirstIdx  = 6;
    localparam int unsigned DstLastIdx   = 9;
    localparam int unsigned UdpLenGap    = 2;
    localparam int unsigned UdpCsumGap   = 3;
    localparam int unsigned IdlePercent  = 11;
    localparam int unsigned ItemTarget   = 1250;
    localparam int unsigned StallLimit   = 1000;
    localparam int unsigned NumDirected  = 17;

    typedef struct packed {
        logic [15:0] index;
        logic [4:0]  hwords;
        logic [16:0] hsum;
        logic [16:0] dsum;
        logic        udp;
        logic        ovf;
    } fixup_state_t;

    typedef struct packed {
        logic [15:0] total_length;
        logic [15:0] header_checksum;
        logic [15:0] udp_length;
        logic [15:0] udp_checksum;
        logic        is_udp;
        logic        length_error;
    } fixup_result_t;

    typedef struct packed {
        logic [16:0]   nwords;
        logic          odd;
        logic [15:0]   first_word;
        logic [15:0]   proto_word;
        logic [15:0]   fill;
        logic          scramble;
        logic          zero_csum;
        logic          typed;
        fixup_result_t want;
    } fixup_case_t;

    localparam fixup_result_t NoWant = '0;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_ready;
    logic [15:0] word = 16'h0000;
    logic        last = 1'b0;
    logic        odd_tail = 1'b0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [15:0] total_length;
    logic [15:0] header_checksum;
    logic [15:0] udp_length;
    logic [15:0] udp_checksum;
    logic        is_udp;
    logic        length_error;

    fixup_state_t  stream_state = '0;
    fixup_result_t awaited_fixups[$];
    logic [15:0]   packet_words[$];
    bit            typed_pending = 1'b0;
    fixup_result_t typed_want = '0;
    bit            steady = 1'b0;
    int unsigned   mismatches = 0;
    int unsigned   items_sent = 0;
    int unsigned   quiet_cycles = 0;

    fixup_case_t directed_cases [NumDirected] = '{
        '{17'd1, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1,
          '{16'h0002, 16'hfffd, 16'h0002, 16'h0000, 1'b0, 1'b0}},
        '{17'd1, 1'b1, 16'hffff, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1,
          '{16'h0001, 16'h00fe, 16'h0000, 16'h0000, 1'b0, 1'b1}},
        '{17'd32768, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1,
          '{16'hffff, 16'h0000, 16'hffff, 16'h0000, 1'b0, 1'b1}},
        '{17'd32768, 1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1,
          '{16'hffff, 16'h0000, 16'hffff, 16'h0000, 1'b0, 1'b0}},
        '{17'd65538, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1,
          '{16'hffff, 16'h0000, 16'hffff, 16'h0000, 1'b0, 1'b1}},
        '{17'd14, 1'b0, 16'h4500, UdpTtlProto, 16'h0000, 1'b1, 1'b0, 1'b0, NoWant},
        '{17'd15, 1'b1, 16'h4500, UdpTtlProto, 16'h0000, 1'b1, 1'b0, 1'b0, NoWant},
        '{17'd16, 1'b0, 16'h4500, UdpTtlProto, 16'h0000, 1'b1, 1'b1, 1'b0, NoWant},
        '{17'd40, 1'b0, 16'h4fff, UdpTtlProto, 16'hffff, 1'b0, 1'b0, 1'b0, NoWant},
        '{17'd12, 1'b0, 16'h4000, UdpTtlProto, 16'h0000, 1'b1, 1'b0, 1'b0, NoWant},
        '{17'd8,  1'b1, 16'h4200, UdpTtlProto, 16'h0000, 1'b1, 1'b0, 1'b0, NoWant},
        '{17'd10, 1'b0, 16'h4400, UdpTtlProto, 16'h0000, 1'b1, 1'b0, 1'b0, NoWant},
        '{17'd3,  1'b0, 16'h4500, UdpTtlProto, 16'h0000, 1'b1, 1'b0, 1'b0, NoWant},
        '{17'd7,  1'b1, 16'h4500, UdpTtlProto, 16'h0000, 1'b1, 1'b0, 1'b0, NoWant},
        '{17'd20, 1'b0, 16'h4500, TcpTtlProto, 16'h0000, 1'b1, 1'b0, 1'b0, NoWant},
        '{17'd10, 1'b0, 16'h4500, UdpTtlProto, 16'h0000, 1'b1, 1'b0, 1'b0, NoWant},
        '{17'd16, 1'b1, 16'h46a5, UdpTtlProto, 16'h0000, 1'b1, 1'b1, 1'b0, NoWant}
    };

    ipv4_udp_length_checksum_fixup dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .word            (word),
        .last            (last),
        .odd_tail        (odd_tail),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .total_length    (total_length),
        .header_checksum (header_checksum),
        .udp_length      (udp_length),
        .udp_checksum    (udp_checksum),
        .is_udp          (is_udp),
        .length_error    (length_error)
    );

    always #6 clk = ~clk;

    function automatic logic [16:0] ones_add(input logic [16:0] acc, input logic [15:0] v);
        int unsigned t;
        begin
            t = 32'(acc) + 32'(v);
            t = (t & 32'hffff) + (t >> 16);
            return t[16:0];
        end
    endfunction

    function automatic logic [15:0] ones_fold(input int unsigned s);
        int unsigned t;
        begin
            t = (s & 32'hffff) + (s >> 16);
            t = (t & 32'hffff) + (t >> 16);
            return t[15:0];
        end
    endfunction

    // Folds one packet word into the running state; returns 1 with the fixed-up
    // fields when the word closes the packet.
    function automatic bit absorb_word(input fixup_state_t cur, input logic [15:0] w_in,
                                       input logic fin, input logic odd_in,
                                       output fixup_state_t nxt, output fixup_result_t res);
        fixup_state_t s;
        logic [15:0]  w;
        logic         odd;
        int unsigned  idx;
        int unsigned  hw;
        int unsigned  bytes;
        int unsigned  total;
        int unsigned  hdr_bytes;
        int unsigned  ulen;
        bit           too_long;
        bit           too_short;
        begin
            s = cur;
            res = '0;
            odd = odd_in & fin;
            w = odd ? (w_in & PadMask) : w_in;
            idx = 32'(s.index);
            if (idx == 0)
                s.hwords = {w[11:8], 1'b0};
            if (idx == ProtoWordIdx)
                s.udp = (w[7:0] == UdpProto);
            hw = 32'(s.hwords);
            if (idx < hw && idx != LenWordIdx && idx != CsumWordIdx)
                s.hsum = ones_add(s.hsum, w);
            if (idx >= hw && idx != hw + UdpLenGap && idx != hw + UdpCsumGap)
                s.dsum = ones_add(s.dsum, w);
            if (idx >= SrcFirstIdx && idx <= DstLastIdx)
                s.dsum = ones_add(s.dsum, w);
            if (!fin)
            begin
                if (s.index == WordMax)
                    s.ovf = 1'b1;
                else
                    s.index = s.index + 16'd1;
                nxt = s;
                return 1'b0;
            end
            bytes = 2 * (idx + 1) - 32'(odd);
            too_long = s.ovf || bytes > 32'(WordMax);
            total = too_long ? 32'(WordMax) : bytes;
            hdr_bytes = 2 * hw;
            too_short = !too_long && total < hdr_bytes;
            ulen = too_short ? 0 : total - hdr_bytes;
            res.total_length = total[15:0];
            res.header_checksum = ~ones_fold(32'(s.hsum) + total);
            res.udp_length = ulen[15:0];
            if (s.udp)
            begin
                res.udp_checksum = ~ones_fold(32'(s.dsum) + 32'(UdpProto) + 2 * ulen);
                if (res.udp_checksum == 16'h0000)
                    res.udp_checksum = WordMax;
            end
            res.is_udp = s.udp;
            res.length_error = too_long || too_short;
            nxt = '0;
            return 1'b1;
        end
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        begin
            if (want !== got)
            begin
                $display("%0t: %s expected %h got %h", $time, name, want, got);
                mismatches++;
            end
        end
    endtask

    always @(negedge clk)
        result_ready <= steady || ($urandom_range(0, 99) >= IdlePercent);

    always @(posedge clk)
    begin : monitor
        fixup_state_t  next_state;
        fixup_result_t fresh;
        fixup_result_t want;
        bit            moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                moved = 1'b1;
                if (awaited_fixups.size() == 0)
                begin
                    $display("%0t: result request with none expected", $time);
                    mismatches++;
                end
                else
                begin
                    want = awaited_fixups.pop_front();
                    check_field("total_length", want.total_length, total_length);
                    check_field("header_checksum", want.header_checksum, header_checksum);
                    check_field("udp_length", want.udp_length, udp_length);
                    check_field("udp_checksum", want.udp_checksum, udp_checksum);
                    check_field("is_udp", {15'd0, want.is_udp}, {15'd0, is_udp});
                    check_field("length_error", {15'd0, want.length_error},
                                {15'd0, length_error});
                end
            end
            if (item_valid && item_ready)
            begin
                moved = 1'b1;
                if (absorb_word(stream_state, word, last, odd_tail, next_state, fresh))
                    awaited_fixups.push_back(typed_pending ? typed_want : fresh);
                stream_state = next_state;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= StallLimit)
            begin
                $display("ipv4_udp_length_checksum_fixup regression: fail");
                $finish;
            end
        end
    end

    // Drives the words held in packet_words as one packet. With zero_csum the
    // final word is chosen so that the UDP sum folds to negative zero. The
    // typed expectation is taken over on a falling edge, once the previous
    // packet has been recorded.
    task automatic send_packet(input bit odd, input bit zero_csum, input bit typed,
                               input fixup_result_t want);
        logic [15:0]   w;
        fixup_state_t  probe_state;
        fixup_result_t probe;
        int unsigned   idx;
        int unsigned   hw;
        bit            fin;
        begin
            for (int i = 0; i < packet_words.size(); i++)
            begin
                fin = (i == packet_words.size() - 1);
                while (!steady && $urandom_range(0, 99) < IdlePercent)
                begin
                    @(negedge clk);
                    item_valid <= 1'b0;
                end
                @(negedge clk);
                if (i == 0)
                begin
                    typed_pending = typed;
                    typed_want = want;
                end
                w = packet_words[i];
                idx = 32'(stream_state.index);
                hw = 32'(stream_state.hwords);
                if (fin && zero_csum && !odd && stream_state.udp && idx >= hw
                    && idx != hw + UdpLenGap && idx != hw + UdpCsumGap
                    && (idx < SrcFirstIdx || idx > DstLastIdx))
                begin
                    void'(absorb_word(stream_state, 16'h0000, 1'b1, 1'b0, probe_state, probe));
                    w = probe.udp_checksum;
                end
                item_valid <= 1'b1;
                word <= w;
                last <= fin;
                odd_tail <= fin ? odd : 1'($urandom_range(0, 1));
                @(posedge clk);
                while (!item_ready)
                    @(posedge clk);
                items_sent++;
            end
        end
    endtask

    initial
    begin : stimulus
        fixup_case_t c;
        logic [15:0] r;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        int unsigned n;
        int unsigned kind;
        bit          odd;
        bit          zero_csum;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int k = 0; k < NumDirected; k++)
        begin
            c = directed_cases[k];
            packet_words.delete();
            for (int i = 0; i < int'(c.nwords); i++)
            begin
                r = 16'($urandom);
                if (i == 0)
                    packet_words.push_back(c.first_word);
                else if (i == ProtoWordIdx)
                    packet_words.push_back(c.proto_word);
                else
                    packet_words.push_back(c.scramble ? r : c.fill);
            end
            send_packet(c.odd, c.zero_csum, c.typed, c.want);
        end

        items_sent = 0;
        while (items_sent < ItemTarget)
        begin
            steady = (items_sent >= 500 && items_sent < 800);
            kind = $urandom_range(0, 99);
            ihl = (kind < 18) ? 4'($urandom_range(0, 4))
                : (kind < 30) ? 4'($urandom_range(6, 15)) : 4'd5;
            proto = ($urandom_range(0, 99) < 75) ? UdpProto : 8'($urandom_range(0, 255));
            n = 2 * 32'(ihl) + 4 + $urandom_range(0, 24);
            if ($urandom_range(0, 99) < 10)
                n = $urandom_range(1, 2 * 32'(ihl) + 4);
            if (kind < 8)
                n = $urandom_range(1, 12);
            odd = 1'($urandom_range(0, 1));
            zero_csum = ($urandom_range(0, 99) < 15);
            packet_words.delete();
            for (int i = 0; i < n; i++)
            begin
                r = 16'($urandom);
                if (kind < 8)
                    packet_words.push_back(r);
                else if (i == 0)
                    packet_words.push_back({4'h4, ihl, r[7:0]});
                else if (i == ProtoWordIdx)
                    packet_words.push_back({r[15:8], proto});
                else
                    packet_words.push_back(r);
            end
            send_packet(odd, zero_csum, 1'b0, NoWant);
        end
        steady = 1'b0;

        @(negedge clk);
        item_valid <= 1'b0;
        while (awaited_fixups.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        if (mismatches == 0)
            $display("ipv4_udp_length_checksum_fixup regression: pass");
        else
            $display("ipv4_udp_length_checksum_fixup regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/udpfix_pkg.sv
rtl/ipv4_udp_length_checksum_fixup.sv
verif/tb.sv
